// ===== hw/rtl/mlfs_pkg.sv =====
// Package for the multilevel feedback scheduler: opcodes, status codes,
// register indexes and sizing defaults. No dependencies.
`default_nettype none
package mlfs_pkg;
   localparam int SLOT_COUNT_DEF  = 16;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam logic [2:0] OP_ADMIT    = 3'd0;
   localparam logic [2:0] OP_RELEASE  = 3'd1;
   localparam logic [2:0] OP_DISPATCH = 3'd2;
   localparam logic [2:0] OP_ADVANCE  = 3'd3;
   localparam logic [2:0] OP_READ     = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_BAD_LEVEL = 2'd2;
   localparam logic [1:0] ST_BLOCKED   = 2'd3;

   localparam logic [1:0] REG_Q1     = 2'd0;
   localparam logic [1:0] REG_Q2     = 2'd1;
   localparam logic [1:0] REG_Q3     = 2'd2;
   localparam logic [1:0] REG_ACTIVE = 2'd3;

   function automatic logic [4:0] sat31(input logic [8:0] v);
      sat31 = (v > 9'd31) ? 5'd31 : v[4:0];
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/multilevel_feedback_scheduler.sv =====
// Multilevel feedback scheduler, top level.
// Depends on mlfs_pkg.
//
// Usage: command items enter on req_ (tdata = opcode[2:0], task_id[18:3],
// task_life[34:19], admit_level[36:35], slot_index[40:37]). One result item
// per command leaves on rsp_. The user must set quanta and the active slot
// count over the csr_ APB port only while the block is idle; the block itself
// does not enforce it. Admit and read pass through the WALK and FINISH states
// before the result is valid. Release, dispatch and advance walk the visited
// slots, one slot per cycle except where dispatch fills a slot, through a
// single slot-update unit. Waiting-queue entries live in one memory with one
// write and one registered read port; each slot that dispatch fills from a
// queue passes through an extra FILL state that takes the registered read.
// req_tready is high only when the sequencer is idle and the result register
// is empty or being drained, so a stalled receiver holds the result and
// blocks the next command. Reset empties all slots and queue pointers and
// restores register defaults; queue memory contents are not cleared.
`default_nettype none
module multilevel_feedback_scheduler
   import mlfs_pkg::*;
#(
   parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // opcode, task_id, task_life, admit_level, slot_index from bit 0; zero fill
   input  wire  [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // status, placed_level, changed_count, finished_count, slot_busy,
   // slot_task_id, slot_life, slot_quantum, slot_level, waiting one/two/three
   output logic [79:0] rsp_tdata,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [3:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SCW = $clog2(SLOT_COUNT + 1);
   localparam int QW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int MW = 2 + QW;

   typedef enum logic [2:0] {IDLE, WALK, POP, FILL, FINISH} state_type;

   typedef struct packed {
      logic [15:0] id;
      logic [15:0] life;
      logic [15:0] quantum;
   } qent_type;

   // slot table
   logic [SLOT_COUNT-1:0] busy_ff;
   logic [15:0] sid_ff [SLOT_COUNT];
   logic [15:0] slife_ff [SLOT_COUNT];
   logic [15:0] squant_ff [SLOT_COUNT];
   logic [1:0]  slevel_ff [SLOT_COUNT];

   qent_type qmem [3*QUEUE_DEPTH];
   qent_type qrd_ff;

   logic [QW-1:0] head_ff [3];
   logic [QW-1:0] tail_ff [3];
   logic [CW-1:0] count_ff [3];

   logic [14:0] quant_ff [3];
   logic [4:0]  active_ff;

   state_type state_ff;
   logic [2:0]  op_ff;
   logic [15:0] tid_ff, tlife_ff;
   logic [1:0]  tlv_ff;
   logic [3:0]  tidx_ff;
   logic [SW-1:0] s_ff;
   logic [SCW-1:0] n_ff;
   logic [1:0] status_ff, placed_ff, poplv_ff;
   logic [8:0] changed_ff, finished_ff;
   logic rbusy_ff;
   logic [15:0] rid_ff, rlife_ff, rquant_ff;
   logic [1:0] rlevel_ff;
   logic out_valid_ff;
   logic [79:0] out_ff;

   // queue write port
   logic wr_en;
   logic [MW-1:0] wr_addr;
   qent_type wr_data;
   logic [MW-1:0] rd_addr;

   function automatic logic [MW-1:0] qaddr(input logic [1:0] q, input logic [QW-1:0] p);
      qaddr = MW'(q) * MW'(QUEUE_DEPTH) + MW'(p);
   endfunction

   function automatic logic [QW-1:0] inc(input logic [QW-1:0] p);
      inc = (32'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
   endfunction

   wire accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == IDLE) && (!out_valid_ff || rsp_tready);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_ff;
   assign csr_pready = 1'b1;

   always_comb begin
      case (csr_paddr[3:2])
         REG_Q1:     csr_prdata = {17'd0, quant_ff[0]};
         REG_Q2:     csr_prdata = {17'd0, quant_ff[1]};
         REG_Q3:     csr_prdata = {17'd0, quant_ff[2]};
         REG_ACTIVE: csr_prdata = {27'd0, active_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // current slot view and demotion target
   wire cur_busy = busy_ff[s_ff];
   wire [15:0] cur_life = slife_ff[s_ff];
   wire [15:0] cur_q = squant_ff[s_ff];
   wire [1:0] cur_lv = slevel_ff[s_ff];
   wire [1:0] dq = cur_lv; // index of next level queue (level+1)-1
   wire dfull = (32'(count_ff[dq]) >= QUEUE_DEPTH);
   wire want_demote = cur_busy && cur_life != 16'd0 && $signed(cur_q) <= 0
                      && (cur_lv == 2'd1 || cur_lv == 2'd2);
   wire [1:0] alq = tlv_ff - 2'd1;
   wire afull = (32'(count_ff[alq]) >= QUEUE_DEPTH);

   logic [1:0] pick;
   logic pick_ok;
   always_comb begin
      pick_ok = 1'b1;
      if (count_ff[0] != '0) pick = 2'd0;
      else if (count_ff[1] != '0) pick = 2'd1;
      else if (count_ff[2] != '0) pick = 2'd2;
      else begin pick = 2'd0; pick_ok = 1'b0; end
   end

   always_comb begin
      wr_en = 1'b0;
      wr_addr = qaddr(alq, tail_ff[alq]);
      wr_data = '{id: tid_ff, life: tlife_ff, quantum: {1'b0, quant_ff[alq]}};
      rd_addr = qaddr(pick, head_ff[pick]);
      if (state_ff == WALK && op_ff == OP_RELEASE) begin
         wr_addr = qaddr(dq, tail_ff[dq]);
         wr_data = '{id: sid_ff[s_ff], life: cur_life, quantum: {1'b0, quant_ff[dq]}};
         wr_en = want_demote && !dfull;
      end else if (state_ff == WALK && op_ff == OP_ADMIT) begin
         wr_en = tlv_ff != 2'd0 && !afull;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) qmem[wr_addr] <= wr_data;
      qrd_ff <= qmem[rd_addr];
   end

   wire last = (32'(s_ff) + 1 >= 32'(n_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         out_valid_ff <= 1'b0;
         busy_ff <= '0;
         for (int q = 0; q < 3; q++) begin
            head_ff[q] <= '0; tail_ff[q] <= '0; count_ff[q] <= '0;
         end
         quant_ff[0] <= 15'd1; quant_ff[1] <= 15'd2; quant_ff[2] <= 15'd4;
         active_ff <= 5'd16;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            case (csr_paddr[3:2])
               REG_Q1:     quant_ff[0] <= csr_pwdata[14:0];
               REG_Q2:     quant_ff[1] <= csr_pwdata[14:0];
               REG_Q3:     quant_ff[2] <= csr_pwdata[14:0];
               REG_ACTIVE: active_ff <= csr_pwdata[4:0];
               default: ;
            endcase
         end
         if (out_valid_ff && rsp_tready) out_valid_ff <= 1'b0;
         case (state_ff)
            IDLE: if (accept) begin
               op_ff <= req_tdata[2:0];
               tid_ff <= req_tdata[18:3];
               tlife_ff <= req_tdata[34:19];
               tlv_ff <= req_tdata[36:35];
               tidx_ff <= req_tdata[40:37];
               s_ff <= '0;
               n_ff <= (32'(active_ff) > SLOT_COUNT) ? SCW'(SLOT_COUNT) : SCW'(active_ff);
               status_ff <= ST_OK; placed_ff <= 2'd0;
               changed_ff <= '0; finished_ff <= '0;
               rbusy_ff <= 1'b0; rid_ff <= '0; rlife_ff <= '0;
               rquant_ff <= '0; rlevel_ff <= '0;
               state_ff <= WALK;
            end
            WALK: begin
               case (op_ff)
                  OP_ADMIT: begin
                     if (tlv_ff == 2'd0) status_ff <= ST_BAD_LEVEL;
                     else if (afull) status_ff <= ST_FULL;
                     else begin
                        placed_ff <= tlv_ff;
                        tail_ff[alq] <= inc(tail_ff[alq]);
                        count_ff[alq] <= count_ff[alq] + 1'b1;
                     end
                     state_ff <= FINISH;
                  end
                  OP_READ: begin
                     if (32'(tidx_ff) < SLOT_COUNT && busy_ff[SW'(tidx_ff)]) begin
                        rbusy_ff <= 1'b1;
                        rid_ff <= sid_ff[SW'(tidx_ff)];
                        rlife_ff <= slife_ff[SW'(tidx_ff)];
                        rquant_ff <= squant_ff[SW'(tidx_ff)];
                        rlevel_ff <= slevel_ff[SW'(tidx_ff)];
                     end
                     state_ff <= FINISH;
                  end
                  OP_RELEASE, OP_DISPATCH, OP_ADVANCE: begin
                     if (n_ff == '0) state_ff <= FINISH;
                     else begin
                        if (op_ff == OP_RELEASE) begin
                           if (cur_busy && cur_life == 16'd0) begin
                              busy_ff[s_ff] <= 1'b0;
                              sid_ff[s_ff] <= '0; slife_ff[s_ff] <= '0;
                              squant_ff[s_ff] <= '0; slevel_ff[s_ff] <= '0;
                              finished_ff <= finished_ff + 1'b1;
                              changed_ff <= changed_ff + 1'b1;
                           end else if (want_demote) begin
                              if (dfull) status_ff <= ST_BLOCKED;
                              else begin
                                 busy_ff[s_ff] <= 1'b0;
                                 sid_ff[s_ff] <= '0; slife_ff[s_ff] <= '0;
                                 squant_ff[s_ff] <= '0; slevel_ff[s_ff] <= '0;
                                 tail_ff[dq] <= inc(tail_ff[dq]);
                                 count_ff[dq] <= count_ff[dq] + 1'b1;
                                 changed_ff <= changed_ff + 1'b1;
                              end
                           end
                        end else if (op_ff == OP_ADVANCE) begin
                           if (cur_busy && cur_life != 16'd0) begin
                              slife_ff[s_ff] <= cur_life - 1'b1;
                              if (cur_q != 16'h8000) squant_ff[s_ff] <= cur_q - 1'b1;
                              changed_ff <= changed_ff + 1'b1;
                           end
                        end
                        if (op_ff == OP_DISPATCH && !cur_busy && pick_ok) begin
                           poplv_ff <= pick;
                           head_ff[pick] <= inc(head_ff[pick]);
                           count_ff[pick] <= count_ff[pick] - 1'b1;
                           changed_ff <= changed_ff + 1'b1;
                           state_ff <= FILL;
                        end else if (last) state_ff <= FINISH;
                        else s_ff <= s_ff + 1'b1;
                     end
                  end
                  default: state_ff <= FINISH;
               endcase
            end
            FILL: begin
               busy_ff[s_ff] <= 1'b1;
               sid_ff[s_ff] <= qrd_ff.id;
               slife_ff[s_ff] <= qrd_ff.life;
               squant_ff[s_ff] <= qrd_ff.quantum;
               slevel_ff[s_ff] <= poplv_ff + 2'd1;
               if (last) state_ff <= FINISH;
               else begin
                  s_ff <= s_ff + 1'b1;
                  state_ff <= WALK;
               end
            end
            FINISH: begin
               out_ff <= {sat31(9'(count_ff[2])), sat31(9'(count_ff[1])),
                          sat31(9'(count_ff[0])), rlevel_ff, rquant_ff, rlife_ff,
                          rid_ff, rbusy_ff, sat31(finished_ff), sat31(changed_ff),
                          placed_ff, status_ff};
               out_valid_ff <= 1'b1;
               state_ff <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/mlfs_checker.sv =====
// Port-level checks for the multilevel feedback scheduler.
// Depends on mlfs_pkg; bound to multilevel_feedback_scheduler.
`default_nettype none
module mlfs_checker
   import mlfs_pkg::*;
(
   input wire clock,
   input wire reset,
   input wire req_tvalid,
   input wire req_tready,
   input wire rsp_tvalid,
   input wire rsp_tready,
   input wire [79:0] rsp_tdata,
   input wire csr_pready
);
   // a command is not taken in the cycle after another was taken
   a_no_back: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready) else $error("ready after accept");
   // a stalled result holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed under stall");
   // waiting counts never exceed 16
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[69:65] <= 5'd16 && rsp_tdata[74:70] <= 5'd16
                      && rsp_tdata[79:75] <= 5'd16)) else $error("count range");
   // an accept never happens while a result waits undrained
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready) else $error("accept over stall");
   a_pready: assert property (@(posedge clock) csr_pready) else $error("pready low");
endmodule

bind multilevel_feedback_scheduler mlfs_checker u_mlfs_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .csr_pready(csr_pready)
);
`default_nettype wire
